@@ src/itaf_pkg.sv @@
`timescale 1ns / 1ps

package itaf_pkg;

    // magnitude width of an unsigned item
    localparam int VALUE_BITS = 64;

    localparam int OPC_W   = 1;
    localparam int VALUE_W = 64;
    localparam int SINT_W  = 32;
    localparam int CHAR_W  = 8;
    localparam int FMT_W   = 2;

    // bcd digit buffer, sized for the widest magnitude
    localparam int DEC_DIGITS = 20;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int HEX_DIGITS = 16;
    localparam int HEX_W      = HEX_DIGITS * 4;
    localparam int DEC_M3     = DEC_DIGITS % 3;

    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W = $clog2(DEC_DIGITS + 1);

    localparam logic [OPC_W-1:0] OPC_SIGNED    = 1'b1;
    localparam logic [FMT_W-1:0] FMT_DEC_COMMA = 2'd0;
    localparam int               FMT_HEX_BIT   = 1;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ALPHA = 8'h37;

    typedef struct packed {
        logic hex;
        logic commas;
        logic neg;
    } t_emit_ctl;

    // digit value to upper-case ascii
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {4'b0000, d};
        hex_char = (d < 4'd10) ? (CH_ZERO + ext) : (CH_ALPHA + ext);
    endfunction

endpackage

@@ src/itaf_if.sv @@
`timescale 1ns / 1ps

interface itaf_in_if;
    import itaf_pkg::*;
    logic               valid;
    logic               ready;
    logic [OPC_W-1:0]   opcode;
    logic [VALUE_W-1:0] value;
    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface itaf_out_if;
    import itaf_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

interface itaf_cfg_if;
    import itaf_pkg::*;
    logic             valid;
    logic             ready;
    logic [FMT_W-1:0] number_format;
    modport source (output valid, output number_format, input ready);
    modport sink   (input valid, input number_format, output ready);
endinterface

@@ src/itaf_dabble.sv @@
`timescale 1ns / 1ps

module itaf_dabble (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [itaf_pkg::VALUE_BITS-1:0]     i_mag,
    output logic                                o_done,
    output logic [itaf_pkg::DIG_W-1:0]          o_bcd
);
    import itaf_pkg::*;

    logic [VALUE_BITS-1:0] r_bin;
    logic [DIG_W-1:0]      r_bcd;
    logic [BIT_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIG_W-1:0]      w_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? (r_bcd[4*i +: 4] + 4'd3)
                                                       : r_bcd[4*i +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == BIT_CNT_W'(1));
            if (i_start) begin
                r_bin  <= i_mag;
                r_bcd  <= '0;
                r_cnt  <= BIT_CNT_W'(VALUE_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_bcd <= {w_adj[DIG_W-2:0], r_bin[VALUE_BITS-1]};
                r_bin <= {r_bin[VALUE_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == BIT_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

@@ src/itaf_emit.sv @@
`timescale 1ns / 1ps

module itaf_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  itaf_pkg::t_emit_ctl         i_ctl,
    input  logic [itaf_pkg::DIG_W-1:0]  i_digits,
    output logic                        o_done,
    itaf_out_if.source                  o_out
);
    import itaf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_ZERO,
        S_X,
        S_SKIP,
        S_DIGIT,
        S_SEP
    } t_state;

    t_state               r_state;
    logic [DIG_W-1:0]     r_dig;
    logic [DIG_CNT_W-1:0] r_k;
    logic [1:0]           r_m3;
    t_emit_ctl            r_ctl;
    logic                 r_valid;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_last;
    logic                 r_done;

    logic                 w_free;
    logic                 w_load;
    logic [3:0]           w_top;
    logic [DIG_CNT_W-1:0] w_k_nx;
    logic [1:0]           w_m3_nx;
    logic                 w_sep;

    assign w_free  = !r_valid || o_out.ready;
    // a character enters the output register this cycle
    assign w_load  = w_free && ((r_state == S_SIGN) || (r_state == S_ZERO) ||
                                (r_state == S_X) || (r_state == S_DIGIT) ||
                                (r_state == S_SEP));
    assign w_top   = r_dig[DIG_W-1 -: 4];
    assign w_k_nx  = r_k - 1'b1;
    assign w_m3_nx = (r_m3 == 2'd0) ? 2'd2 : (r_m3 - 2'd1);
    // separator after this digit, judged by the digits left to its right
    assign w_sep   = r_ctl.hex ? (w_k_nx[1:0] == 2'b00) : (r_ctl.commas && (w_m3_nx == 2'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_DIGIT) && w_free && (w_k_nx == '0);
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (r_valid && o_out.ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dig <= i_digits;
                        r_ctl <= i_ctl;
                        r_k   <= i_ctl.hex ? DIG_CNT_W'(HEX_DIGITS) : DIG_CNT_W'(DEC_DIGITS);
                        r_m3  <= 2'(DEC_M3);
                        if (i_ctl.neg) begin
                            r_state <= S_SIGN;
                        end else if (i_ctl.hex) begin
                            r_state <= S_ZERO;
                        end else begin
                            r_state <= S_SKIP;
                        end
                    end
                end
                S_SIGN: begin
                    if (w_free) begin
                        r_char  <= CH_MINUS;
                        r_last  <= 1'b0;
                        r_state <= r_ctl.hex ? S_ZERO : S_SKIP;
                    end
                end
                S_ZERO: begin
                    if (w_free) begin
                        r_char  <= CH_ZERO;
                        r_last  <= 1'b0;
                        r_state <= S_X;
                    end
                end
                S_X: begin
                    if (w_free) begin
                        r_char  <= CH_X;
                        r_last  <= 1'b0;
                        r_state <= S_DIGIT;
                    end
                end
                S_SKIP: begin
                    // drop leading zeros, keeping at least one digit
                    if ((w_top == 4'd0) && (r_k > DIG_CNT_W'(1))) begin
                        r_dig <= {r_dig[DIG_W-5:0], 4'd0};
                        r_k   <= w_k_nx;
                        r_m3  <= w_m3_nx;
                    end else begin
                        r_state <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (w_free) begin
                        r_char  <= hex_char(w_top);
                        r_last  <= (w_k_nx == '0);
                        r_dig   <= {r_dig[DIG_W-5:0], 4'd0};
                        r_k     <= w_k_nx;
                        r_m3    <= w_m3_nx;
                        if (w_k_nx == '0) begin
                            r_state <= S_IDLE;
                        end else if (w_sep) begin
                            r_state <= S_SEP;
                        end
                    end
                end
                S_SEP: begin
                    if (w_free) begin
                        r_char  <= r_ctl.hex ? CH_DASH : CH_COMMA;
                        r_last  <= 1'b0;
                        r_state <= S_DIGIT;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.text_char = r_char;
    assign o_out.last_char = r_last;
    assign o_done          = r_done;

endmodule

@@ src/integer_to_ascii_formatter_top.sv @@
// timing: hex goes straight to the character sequencer when the word is taken; decimal first runs
//   bit-serial double dabble, and its first digit waits further for each dropped leading
//   zero (the '-' of a negative value comes out before the zeros are dropped)
// throughput: one character per cycle while the output is not stalled; the next word is taken
//   only once the last character of the previous one is in the output register
// reset: synchronous active-low i_rst_n clears all control state, format decimal with commas
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itaf_cfg_if.sink    i_cfg,
    itaf_in_if.sink     i_in,
    itaf_out_if.source  o_out
);
    import itaf_pkg::*;

    // item sequencing: take a word, convert if decimal, then stream characters
    typedef enum logic [1:0] {
        T_IDLE,
        T_CONV,
        T_EMIT
    } t_state;

    t_state            r_state;
    logic [FMT_W-1:0]  r_fmt;
    t_emit_ctl         r_ctl;

    logic                  w_acc;
    logic [SINT_W-1:0]     w_low;
    logic                  w_signed;
    logic                  w_neg;
    logic [SINT_W-1:0]     w_abs32;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_hex;
    t_emit_ctl             w_ctl;
    t_emit_ctl             w_emit_ctl;
    logic [DIG_W-1:0]      w_hex_dig;
    logic [DIG_W-1:0]      w_emit_dig;
    logic                  w_conv_start;
    logic                  w_conv_done;
    logic [DIG_W-1:0]      w_bcd;
    logic                  w_emit_start;
    logic                  w_emit_done;

    // config register is always writable
    assign i_cfg.ready = 1'b1;

    // one item at a time: input is open only between items
    assign i_in.ready = (r_state == T_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;

    // magnitude and sign of the incoming word
    assign w_low    = i_in.value[SINT_W-1:0];
    assign w_signed = (i_in.opcode == OPC_SIGNED);
    assign w_neg    = w_signed && w_low[SINT_W-1];
    assign w_abs32  = w_neg ? (SINT_W'(0) - w_low) : w_low;
    assign w_mag    = w_signed ? VALUE_BITS'(w_abs32) : i_in.value[VALUE_BITS-1:0];

    // format code 3 falls into hex as well
    assign w_hex        = r_fmt[FMT_HEX_BIT];
    assign w_ctl.hex    = w_hex;
    assign w_ctl.commas = (r_fmt == FMT_DEC_COMMA);
    assign w_ctl.neg    = w_neg;

    // hex digits are the magnitude nibbles, top-aligned in the digit buffer
    assign w_hex_dig = {HEX_W'(w_mag), {(DIG_W - HEX_W){1'b0}}};

    // hex starts the character stream at once, decimal once conversion is done
    assign w_conv_start = w_acc && !w_hex;
    assign w_emit_start = (w_acc && w_hex) || w_conv_done;
    assign w_emit_ctl   = (r_state == T_IDLE) ? w_ctl : r_ctl;
    assign w_emit_dig   = (r_state == T_IDLE) ? w_hex_dig : w_bcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_fmt   <= FMT_DEC_COMMA;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_fmt <= i_cfg.number_format;
            end
            case (r_state)
                T_IDLE: begin
                    if (w_acc) begin
                        r_ctl   <= w_ctl;
                        r_state <= w_hex ? T_EMIT : T_CONV;
                    end
                end
                T_CONV: begin
                    if (w_conv_done) begin
                        r_state <= T_EMIT;
                    end
                end
                T_EMIT: begin
                    // last character is in the output register; next word may enter
                    if (w_emit_done) begin
                        r_state <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end

    // bit-serial binary to bcd
    itaf_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_conv_start),
        .i_mag   (w_mag),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    // digit-serial character sequencer with output register
    itaf_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_emit_start),
        .i_ctl    (w_emit_ctl),
        .i_digits (w_emit_dig),
        .o_done   (w_emit_done),
        .o_out    (o_out)
    );

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import itaf_pkg::*;

    // format codes as written to the register
    localparam logic [FMT_W-1:0] FMT_DEC_PLAIN = 2'd1;
    localparam logic [FMT_W-1:0] FMT_HEX       = 2'd2;
    localparam logic [FMT_W-1:0] FMT_HEX_ALT   = 2'd3;

    localparam logic [OPC_W-1:0]  OPC_UNSIGNED = 1'b0;
    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int REPORT_MAX   = 10;

    // expected text for each accepted number, checked char by char
    class char_scoreboard;
        typedef struct {
            logic [CHAR_W-1:0] text_char;
            logic              last_char;
        } t_char_word;

        t_char_word        expected_chars[$];
        logic [FMT_W-1:0]  number_format = FMT_DEC_COMMA;
        int                errors = 0;

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_MAX)
                $display("ERROR @%0t: %s", $time, msg);
        endfunction

        function void push_char(logic [CHAR_W-1:0] c);
            t_char_word w;
            w.text_char = c;
            w.last_char = 1'b0;
            expected_chars.push_back(w);
        endfunction

        // predicted text of one number under the current format
        function void note_number(logic [OPC_W-1:0] opcode, logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0] mag;
            logic [SINT_W-1:0]  low;
            logic [3:0]         nib;
            logic [3:0]         digits[$];
            int                 start;
            int                 k;
            start = expected_chars.size();
            if (opcode == OPC_SIGNED) begin
                low = value[SINT_W-1:0];
                if (low[SINT_W-1]) begin
                    push_char(CH_MINUS);
                    low = -low;
                end
                mag = {{(VALUE_W-SINT_W){1'b0}}, low};
            end else begin
                mag = value;
                if (VALUE_BITS < VALUE_W)
                    mag = mag & ((64'd1 << VALUE_BITS) - 64'd1);
            end
            if (number_format[FMT_HEX_BIT]) begin
                push_char(CH_ZERO);
                push_char(CH_X);
                for (k = 15; k >= 0; k--) begin
                    if (k == 11 || k == 7 || k == 3)
                        push_char(CH_DASH);
                    nib = mag[4*k +: 4];
                    push_char(nib < 4'd10 ? CH_ZERO + nib : CH_UPPER_A + nib - 8'd10);
                end
            end else if (mag == 0) begin
                push_char(CH_ZERO);
            end else begin
                while (mag != 0) begin
                    digits.push_back(4'(mag % 10));
                    mag = mag / 10;
                end
                // k digits still to the right of this one
                for (k = digits.size() - 1; k >= 0; k--) begin
                    push_char(CH_ZERO + digits[k]);
                    if (number_format == FMT_DEC_COMMA && k > 0 && k % 3 == 0)
                        push_char(CH_COMMA);
                end
            end
            if (expected_chars.size() > start)
                expected_chars[expected_chars.size() - 1].last_char = 1'b1;
        endfunction

        function void check_char(logic [CHAR_W-1:0] got_char, logic got_last);
            t_char_word want;
            if (expected_chars.size() == 0) begin
                flag($sformatf("unexpected char 0x%02h last %0b", got_char, got_last));
                return;
            end
            want = expected_chars.pop_front();
            if (got_char !== want.text_char)
                flag($sformatf("text_char: expected 0x%02h, got 0x%02h",
                               want.text_char, got_char));
            if (got_last !== want.last_char)
                flag($sformatf("last_char: expected %0b, got %0b (char 0x%02h)",
                               want.last_char, got_last, want.text_char));
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   no_idle;
    int   idle_cycles = 0;

    char_scoreboard scoreboard = new();

    itaf_cfg_if cfg_if ();
    itaf_in_if  in_if ();
    itaf_out_if out_if ();

    integer_to_ascii_formatter_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 3);
    endfunction

    // spread magnitudes so every digit count shows up
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 63);
            1: v = v >> $urandom_range(44, 63);
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_number(logic [OPC_W-1:0] opcode, logic [VALUE_W-1:0] value);
        int gap;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            in_if.valid = 1'b0;
        end
        @(negedge i_clk);
        in_if.valid  = 1'b1;
        in_if.opcode = opcode;
        in_if.value  = value;
        do @(posedge i_clk); while (!in_if.ready);
        scoreboard.note_number(opcode, value);
    endtask

    // stop sending and let every expected char come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (scoreboard.expected_chars.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_format(logic [FMT_W-1:0] fmt);
        wait_drained();
        @(negedge i_clk);
        cfg_if.valid         = 1'b1;
        cfg_if.number_format = fmt;
        do @(posedge i_clk); while (!cfg_if.ready);
        scoreboard.number_format = fmt;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // output side: random stalls, check each accepted word
    initial begin : char_sink
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            repeat (stall) begin
                @(negedge i_clk);
                out_if.ready = 1'b0;
            end
            @(negedge i_clk);
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1);
            scoreboard.check_char(out_if.text_char, out_if.last_char);
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) === 1'b1 || (out_if.valid && out_if.ready) === 1'b1 ||
            (cfg_if.valid && cfg_if.ready) === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int n;
        no_idle              = 1'b0;
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.opcode         = OPC_UNSIGNED;
        in_if.value          = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.number_format = FMT_DEC_COMMA;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // decimal with commas: zero, group edges, widest values, signed corners
        write_format(FMT_DEC_COMMA);
        send_number(OPC_UNSIGNED, 64'd0);
        send_number(OPC_UNSIGNED, 64'd1);
        send_number(OPC_UNSIGNED, 64'd999);
        send_number(OPC_UNSIGNED, 64'd1000);
        send_number(OPC_UNSIGNED, 64'd123456789);
        send_number(OPC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(OPC_UNSIGNED, 64'd10000000000000000000);
        send_number(OPC_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF);     // -1
        send_number(OPC_SIGNED, 64'hDEAD_BEEF_8000_0000);     // most negative, junk on top
        send_number(OPC_SIGNED, 64'h0000_0000_7FFF_FFFF);
        send_number(OPC_SIGNED, 64'hFFFF_FFFF_0000_0000);     // signed zero, junk on top

        // plain decimal
        write_format(FMT_DEC_PLAIN);
        send_number(OPC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(OPC_UNSIGNED, 64'd0);
        send_number(OPC_SIGNED, 64'h0000_0000_8000_0000);
        send_number(OPC_UNSIGNED, 64'd1000000);

        // hex with dashes, zero keeps the full padded form
        write_format(FMT_HEX);
        send_number(OPC_UNSIGNED, 64'd0);
        send_number(OPC_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(OPC_UNSIGNED, 64'h0123_4567_89AB_CDEF);
        send_number(OPC_SIGNED, 64'h1234_5678_FFFF_FFFF);
        send_number(OPC_SIGNED, 64'hFFFF_FFFF_7FFF_FFFF);

        // code 3 falls back to hex
        write_format(FMT_HEX_ALT);
        send_number(OPC_UNSIGNED, 64'hFEDC_BA98_7654_3210);
        send_number(OPC_SIGNED, 64'h0000_0000_8000_0000);

        // random phases, each under its own format
        for (phase = 0; phase < 10; phase++) begin
            write_format(FMT_W'($urandom_range(0, 3)));
            no_idle = ($urandom_range(0, 3) == 0);
            for (n = 0; n < 21; n++) begin
                if ($urandom_range(0, 29) == 0)
                    wait_drained();
                send_number(OPC_W'($urandom_range(0, 1)), random_value());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (scoreboard.expected_chars.size() != 0)
            scoreboard.flag($sformatf("%0d expected chars never came",
                                      scoreboard.expected_chars.size()));
        if (scoreboard.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
